### hdl/dnsap_pkg.sv
// Package for the DNS answer parser: parse phases, result codes, packet state type
// and the protocol constants used by the parser and its testbench.
// No dependencies.
package dnsap_pkg;

   // Result codes carried on the result channel's tuser.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_ERROR     = 2'd2
   } status_type;

   // Where in the message the next byte falls.
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_NAME   = 3'd1,
      PH_LABEL  = 3'd2,
      PH_PTR2   = 3'd3,
      PH_QTAIL  = 3'd4,
      PH_FIXED  = 3'd5,
      PH_DATA   = 3'd6
   } phase_type;

   // Register indexes on the configuration channel.
   localparam logic [1:0] CSR_EXPECTED_ID = 2'd0;
   localparam logic [1:0] CSR_WANT_IPV6   = 2'd1;

   // Header flag bits and response codes.
   localparam logic [15:0] FLAG_RESPONSE  = 16'h8000;
   localparam logic [15:0] FLAG_TRUNCATED = 16'h0200;
   localparam logic [15:0] RCODE_MASK     = 16'h000f;
   localparam logic [15:0] RCODE_NXDOMAIN = 16'd3;

   // Name encoding.
   localparam logic [7:0] LABEL_KIND_MASK = 8'hc0;
   localparam logic [7:0] LABEL_LEN_MASK  = 8'h3f;

   // Record matching.
   localparam logic [15:0] CLASS_IN     = 16'd1;
   localparam logic [15:0] TYPE_A       = 16'd1;
   localparam logic [15:0] TYPE_AAAA    = 16'd28;
   localparam logic [15:0] LEN_A        = 16'd4;
   localparam logic [15:0] LEN_AAAA     = 16'd16;

   // Byte positions within the header, the question tail and the record fixed part.
   localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
   localparam logic [3:0] QTAIL_BYTES    = 4'd4;
   localparam logic [3:0] FIX_RDLEN_IDX  = 4'd8;
   localparam logic [3:0] FIX_LAST_IDX   = 4'd9;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  field_index;
      logic [15:0] questions_left;
      logic [15:0] answers_left;
      logic [5:0]  label_left;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [15:0] data_left;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      status_type  verdict;
      logic        verdict_fixed;
   } pkt_state_type;

   localparam pkt_state_type PKT_RESET = '{
      phase:          PH_HEADER,
      field_index:    4'd0,
      questions_left: 16'd0,
      answers_left:   16'd0,
      label_left:     6'd0,
      record_type:    16'd0,
      record_class:   16'd0,
      data_left:      16'd0,
      addr_high:      64'd0,
      addr_low:       64'd0,
      verdict:        ST_OK,
      verdict_fixed:  1'b0
   };

endpackage

### hdl/dns_answer_parser.sv
// DNS response parser: extracts the first matching A or AAAA address from a
// byte stream. Depends on dnsap_pkg.
//
// Usage
// -----
// The request channel (req_*) carries one byte of a DNS response payload per
// beat, with req_tlast marking the final byte. The configuration channel
// (csr_*) writes the expected transaction ID (index 0) and the IPv4/IPv6
// selection (index 1); it is always ready and should only be written between
// messages. The result channel (rsp_*) carries exactly one beat per message:
// the status on rsp_tuser and the raw address on rsp_tdata.
//
// Throughput is one byte per clock: each byte only updates a handful of
// counters and shift registers in the packet state register. The result is
// registered, so it appears on the cycle after the last byte is accepted.
// A finished result may wait in the output register while the next message's
// bytes keep flowing; only the final byte of a message is held off, and only
// if the previous result has not yet been taken.
//
// Reset clears the packet state, the output valid flag (not the output data) and
// both configuration registers (ID zero, IPv4 selected).
module dns_answer_parser
   import dnsap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   // Result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] addr_high, [127:64] addr_low
   output logic [1:0]   rsp_tuser,   // [1:0] status
   // Configuration channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   logic [15:0]   expected_id_ff;
   logic          want_ipv6_ff;

   pkt_state_type pkt_ff, pkt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [63:0]   rsp_high_ff, rsp_high_in;
   logic [63:0]   rsp_low_ff, rsp_low_in;

   logic          req_fire;
   logic          rsp_fire;

   // A result left in the output register blocks only a byte that would
   // produce another one.
   assign req_tready = !(rsp_valid_ff && !rsp_tready) || !req_tlast;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_low_ff, rsp_high_ff};

   // ---------------------------------------------------------------
   // Helpers for the per-byte state update
   // ---------------------------------------------------------------
   function automatic pkt_state_type fix(pkt_state_type s, status_type v);
      pkt_state_type r;
      r               = s;
      r.verdict       = v;
      r.verdict_fixed = 1'b1;
      return r;
   endfunction

   // Begin the next question or answer entry, or conclude that nothing matched.
   function automatic pkt_state_type start_entry(pkt_state_type s);
      pkt_state_type r;
      r             = s;
      r.field_index = 4'd0;
      if (s.questions_left != 16'd0 || s.answers_left != 16'd0) begin
         r.phase = PH_NAME;
      end else begin
         r = fix(r, ST_NOT_FOUND);
      end
      return r;
   endfunction

   function automatic pkt_state_type end_name(pkt_state_type s);
      pkt_state_type r;
      r              = s;
      r.field_index  = 4'd0;
      r.record_type  = 16'd0;
      r.record_class = 16'd0;
      r.phase        = (s.questions_left != 16'd0) ? PH_QTAIL : PH_FIXED;
      return r;
   endfunction

   function automatic pkt_state_type end_record(pkt_state_type s);
      pkt_state_type r;
      r              = s;
      r.answers_left = s.answers_left - 16'd1;
      return start_entry(r);
   endfunction

   // ---------------------------------------------------------------
   // Per-byte state update and result formation
   // ---------------------------------------------------------------
   always_comb begin
      pkt_state_type s;
      logic [15:0]   want_type;
      logic [15:0]   want_len;
      logic [3:0]    fi_next;
      logic [5:0]    lab_next;
      logic [15:0]   dl_next;

      s         = pkt_ff;
      want_type = want_ipv6_ff ? TYPE_AAAA : TYPE_A;
      want_len  = want_ipv6_ff ? LEN_AAAA : LEN_A;
      fi_next   = pkt_ff.field_index + 4'd1;
      lab_next  = pkt_ff.label_left - 6'd1;
      dl_next   = pkt_ff.data_left - 16'd1;

      rsp_valid_in  = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;

      if (req_fire && !pkt_ff.verdict_fixed) begin
         unique case (pkt_ff.phase)
            PH_HEADER: begin
               if (pkt_ff.field_index < 4'd2) begin
                  s.record_type = {pkt_ff.record_type[7:0], req_tdata};
               end else if (pkt_ff.field_index < 4'd4) begin
                  s.record_class = {pkt_ff.record_class[7:0], req_tdata};
               end else if (pkt_ff.field_index < 4'd6) begin
                  s.questions_left = {pkt_ff.questions_left[7:0], req_tdata};
               end else if (pkt_ff.field_index < 4'd8) begin
                  s.answers_left = {pkt_ff.answers_left[7:0], req_tdata};
               end
               if (pkt_ff.field_index >= HDR_LAST_IDX) begin
                  // ID and flags were gathered in the type and class fields.
                  if (pkt_ff.record_type != expected_id_ff
                      || (pkt_ff.record_class & FLAG_RESPONSE) == 16'd0
                      || (pkt_ff.record_class & FLAG_TRUNCATED) != 16'd0) begin
                     s = fix(s, ST_ERROR);
                  end else if ((pkt_ff.record_class & RCODE_MASK) == RCODE_NXDOMAIN) begin
                     s = fix(s, ST_NOT_FOUND);
                  end else if ((pkt_ff.record_class & RCODE_MASK) != 16'd0) begin
                     s = fix(s, ST_ERROR);
                  end else begin
                     s = start_entry(s);
                  end
               end else begin
                  s.field_index = fi_next;
               end
            end
            PH_NAME: begin
               if (req_tdata == 8'd0) begin
                  s = end_name(s);
               end else if ((req_tdata & LABEL_KIND_MASK) == LABEL_KIND_MASK) begin
                  s.phase = PH_PTR2;
               end else if ((req_tdata & LABEL_KIND_MASK) != 8'd0) begin
                  s = fix(s, ST_ERROR);
               end else begin
                  s.label_left = req_tdata[5:0];
                  s.phase      = PH_LABEL;
               end
            end
            PH_LABEL: begin
               s.label_left = lab_next;
               if (lab_next == 6'd0) begin
                  s.phase = PH_NAME;
               end
            end
            PH_PTR2: begin
               // The second pointer byte always ends the name.
               s = end_name(s);
            end
            PH_QTAIL: begin
               s.field_index = fi_next;
               if (fi_next >= QTAIL_BYTES) begin
                  s.questions_left = pkt_ff.questions_left - 16'd1;
                  s = start_entry(s);
               end
            end
            PH_FIXED: begin
               if (pkt_ff.field_index < 4'd2) begin
                  s.record_type = {pkt_ff.record_type[7:0], req_tdata};
               end else if (pkt_ff.field_index < 4'd4) begin
                  s.record_class = {pkt_ff.record_class[7:0], req_tdata};
               end else if (pkt_ff.field_index >= FIX_RDLEN_IDX) begin
                  s.data_left = {pkt_ff.data_left[7:0], req_tdata};
               end
               if (pkt_ff.field_index >= FIX_LAST_IDX) begin
                  // A record that does not match gets class zero, so its data
                  // is skipped without being gathered.
                  if (pkt_ff.record_class == CLASS_IN && pkt_ff.record_type == want_type
                      && s.data_left == want_len) begin
                     s.addr_high = 64'd0;
                     s.addr_low  = 64'd0;
                  end else begin
                     s.record_type  = 16'd0;
                     s.record_class = 16'd0;
                  end
                  if (s.data_left == 16'd0) begin
                     s = end_record(s);
                  end else begin
                     s.phase = PH_DATA;
                  end
               end else begin
                  s.field_index = fi_next;
               end
            end
            PH_DATA: begin
               if (pkt_ff.record_class == CLASS_IN) begin
                  s.addr_high = {pkt_ff.addr_high[55:0], pkt_ff.addr_low[63:56]};
                  s.addr_low  = {pkt_ff.addr_low[55:0], req_tdata};
               end
               s.data_left = dl_next;
               if (dl_next == 16'd0) begin
                  if (pkt_ff.record_class == CLASS_IN) begin
                     s = fix(s, ST_OK);
                  end else begin
                     s = end_record(s);
                  end
               end
            end
            default: begin
               s = fix(s, ST_ERROR);
            end
         endcase
      end

      pkt_in = s;

      // The last byte produces the result and returns the packet state to reset.
      if (req_fire && req_tlast) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = s.verdict_fixed ? s.verdict : ST_ERROR;
         rsp_high_in   = (rsp_status_in == ST_OK) ? s.addr_high : 64'd0;
         rsp_low_in    = (rsp_status_in == ST_OK) ? s.addr_low : 64'd0;
         pkt_in        = PKT_RESET;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'd0;
         want_ipv6_ff   <= 1'b0;
         pkt_ff         <= PKT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_EXPECTED_ID) begin
               expected_id_ff <= csr_wdata;
            end else if (csr_index == CSR_WANT_IPV6) begin
               want_ipv6_ff <= csr_wdata[0];
            end
         end
         pkt_ff       <= pkt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_low_ff    <= rsp_low_in;
   end

endmodule

### hdl/dnsap_checker.sv
// Port-level checker for the DNS answer parser, bound to its top level.
// Depends on dnsap_pkg and dns_answer_parser.
module dnsap_checker
   import dnsap_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [15:0]  csr_wdata
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Accepting the final byte always produces a result on the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no result after final byte");

   // A new result appears only after a final byte was accepted.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result without a final byte");

   // Status is a defined code and the address is zero unless found.
   a_status_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK
                      || ((rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_ERROR)
                          && rsp_tdata == 128'd0)))
      else $error("bad status or stray address");

endmodule

bind dns_answer_parser dnsap_checker u_dnsap_checker (.*);

### test/tb_top.sv
// Self-checking testbench for dns_answer_parser: builds DNS response messages byte by byte,
// predicts each verdict and address, and compares every result beat against the prediction.
// Depends on dnsap_pkg and the dns_answer_parser RTL.
module tb_top;
   import dnsap_pkg::*;

   // Response code that is neither success nor name-error, used to provoke the error path.
   localparam logic [15:0] RCODE_SERVFAIL = 16'd2;
   // Cycles without any completed handshake before the run is declared hung. The longest
   // legitimate quiet stretch is a long sender gap, a long receiver stall or the short settling
   // pause before a register write, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   dns_answer_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // One predicted result: what the parser should report for a message.
   typedef struct {
      status_type  status;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } answer_type;

   answer_type  expected_answers[$];
   logic [7:0]  msg_bytes[$];     // message under construction
   bit          failed = 1'b0;
   bit          steady = 1'b0;    // when set, neither side inserts gaps or stalls
   int          quiet_cycles = 0;
   int          ready_hold = 0;

   // ---------------------------------------------------------------------------------
   // Verdict predictor. It mirrors the parser's packet state: the header and fixed
   // record parts are gathered into the type and class registers, names are walked
   // label by label, and the address shift register fills only for a matching record.
   // ---------------------------------------------------------------------------------
   logic [15:0] cfg_id;
   logic        cfg_ipv6;

   phase_type   p_phase;
   logic [3:0]  p_idx;
   logic [15:0] p_questions;
   logic [15:0] p_answers;
   logic [5:0]  p_label;
   logic [15:0] p_type;
   logic [15:0] p_class;
   logic [15:0] p_data_left;
   logic [63:0] p_acc_hi;
   logic [63:0] p_acc_lo;
   status_type  p_verdict;
   logic        p_done;

   function automatic void settle(input status_type v);
      p_verdict = v;
      p_done    = 1'b1;
   endfunction

   function automatic void clear_packet();
      p_phase     = PH_HEADER;
      p_idx       = '0;
      p_questions = '0;
      p_answers   = '0;
      p_label     = '0;
      p_type      = '0;
      p_class     = '0;
      p_data_left = '0;
      p_acc_hi    = '0;
      p_acc_lo    = '0;
      p_verdict   = ST_OK;
      p_done      = 1'b0;
   endfunction

   // Start the next question or answer entry; running out of both means nothing matched.
   function automatic void open_entry();
      p_idx = '0;
      if (p_questions != 0 || p_answers != 0) p_phase = PH_NAME;
      else settle(ST_NOT_FOUND);
   endfunction

   function automatic void close_name();
      p_idx   = '0;
      p_type  = '0;
      p_class = '0;
      p_phase = (p_questions != 0) ? PH_QTAIL : PH_FIXED;
   endfunction

   function automatic void close_record();
      p_answers = p_answers - 16'd1;
      open_entry();
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic last);
      answer_type  ans;
      logic [15:0] want_type;
      logic [15:0] want_len;
      if (!p_done) begin
         case (p_phase)
            PH_HEADER: begin
               if (p_idx < 4'd2) p_type = {p_type[7:0], b};
               else if (p_idx < 4'd4) p_class = {p_class[7:0], b};
               else if (p_idx < 4'd6) p_questions = {p_questions[7:0], b};
               else if (p_idx < 4'd8) p_answers = {p_answers[7:0], b};
               if (p_idx >= HDR_LAST_IDX) begin
                  // The ID sits in the type register and the flags in the class register.
                  if (p_type != cfg_id || (p_class & FLAG_RESPONSE) == 0 ||
                      (p_class & FLAG_TRUNCATED) != 0)
                     settle(ST_ERROR);
                  else if ((p_class & RCODE_MASK) == RCODE_NXDOMAIN)
                     settle(ST_NOT_FOUND);
                  else if ((p_class & RCODE_MASK) != 0)
                     settle(ST_ERROR);
                  else
                     open_entry();
               end else begin
                  p_idx = p_idx + 4'd1;
               end
            end
            PH_NAME: begin
               if (b == 8'h00) close_name();
               else if ((b & LABEL_KIND_MASK) == LABEL_KIND_MASK) p_phase = PH_PTR2;
               else if ((b & LABEL_KIND_MASK) != 0) settle(ST_ERROR);
               else begin
                  p_label = 6'(b & LABEL_LEN_MASK);
                  p_phase = PH_LABEL;
               end
            end
            PH_LABEL: begin
               p_label = p_label - 6'd1;
               if (p_label == 0) p_phase = PH_NAME;
            end
            PH_PTR2: close_name();
            PH_QTAIL: begin
               p_idx = p_idx + 4'd1;
               if (p_idx >= QTAIL_BYTES) begin
                  p_questions = p_questions - 16'd1;
                  open_entry();
               end
            end
            PH_FIXED: begin
               if (p_idx < 4'd2) p_type = {p_type[7:0], b};
               else if (p_idx < 4'd4) p_class = {p_class[7:0], b};
               else if (p_idx >= FIX_RDLEN_IDX) p_data_left = {p_data_left[7:0], b};
               if (p_idx >= FIX_LAST_IDX) begin
                  want_type = cfg_ipv6 ? TYPE_AAAA : TYPE_A;
                  want_len  = cfg_ipv6 ? LEN_AAAA : LEN_A;
                  // A record that does not match has its class cleared, so its data is
                  // skipped without touching the address register.
                  if (p_class == CLASS_IN && p_type == want_type && p_data_left == want_len)
                  begin
                     p_acc_hi = '0;
                     p_acc_lo = '0;
                  end else begin
                     p_type  = '0;
                     p_class = '0;
                  end
                  if (p_data_left == 0) close_record();
                  else p_phase = PH_DATA;
               end else begin
                  p_idx = p_idx + 4'd1;
               end
            end
            PH_DATA: begin
               if (p_class == CLASS_IN) begin
                  p_acc_hi = {p_acc_hi[55:0], p_acc_lo[63:56]};
                  p_acc_lo = {p_acc_lo[55:0], b};
               end
               p_data_left = p_data_left - 16'd1;
               if (p_data_left == 0) begin
                  if (p_class == CLASS_IN) settle(ST_OK);
                  else close_record();
               end
            end
            default: settle(ST_ERROR);
         endcase
      end
      if (last) begin
         // A message that ends before any verdict was reached is malformed.
         ans.status    = p_done ? p_verdict : ST_ERROR;
         ans.addr_high = (ans.status == ST_OK) ? p_acc_hi : '0;
         ans.addr_low  = (ans.status == ST_OK) ? p_acc_lo : '0;
         expected_answers.push_back(ans);
         clear_packet();
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Monitor and checker. Everything is sampled at the rising edge, where the inputs
   // have been stable since the falling edge. The result beat is checked before the
   // request beat of the same edge is predicted; a result can never belong to a byte
   // taken at the same edge because the parser registers its output.
   // ---------------------------------------------------------------------------------
   answer_type got;

   always @(posedge clock) begin
      if (reset) begin
         cfg_id   = '0;
         cfg_ipv6 = 1'b0;
         clear_packet();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("result beat with no result expected: status %0d", rsp_tuser);
               failed = 1'b1;
            end else begin
               got = expected_answers.pop_front();
               if (rsp_tuser != got.status) begin
                  $error("status: expected %0d, actual %0d", got.status, rsp_tuser);
                  failed = 1'b1;
               end
               if (rsp_tdata[63:0] != got.addr_high) begin
                  $error("addr_high: expected %h, actual %h", got.addr_high, rsp_tdata[63:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[127:64] != got.addr_low) begin
                  $error("addr_low: expected %h, actual %h", got.addr_low, rsp_tdata[127:64]);
                  failed = 1'b1;
               end
            end
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_EXPECTED_ID) cfg_id = csr_wdata;
            else if (csr_index == CSR_WANT_IPV6) cfg_ipv6 = csr_wdata[0];
         end
      end
   end

   // Watchdog: a long run of edges with no beat on any channel means the parser hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no beat on any channel for %0d cycles", QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Result-side back-pressure: runs of ready, short stalls and the odd long stall, each
   // held for a random number of cycles. In steady stretches ready goes high once any current hold runs out.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               rsp_tready <= 1'b1;
               ready_hold = $urandom_range(0, 5);
            end
            18, 19: begin
               rsp_tready <= 1'b0;
               ready_hold = $urandom_range(10, 40);
            end
            default: begin
               rsp_tready <= 1'b0;
               ready_hold = $urandom_range(0, 3);
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Driving. All inputs change at the falling edge only. The request valid stays high
   // between back-to-back beats and is only lowered for a gap or when the channel goes
   // idle, so it never sees two assignments in one step.
   // ---------------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      int r;
      if (steady) begin
         gap = 0;
      end else begin
         r   = $urandom_range(0, 99);
         gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_message();
      steady = ($urandom_range(0, 4) == 0);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   // Drop the request valid, let every predicted result drain, and let the parser settle,
   // since the output register clears its valid only in the cycle after a result is taken.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Message construction helpers. They append to msg_bytes in wire order (big endian).
   // ---------------------------------------------------------------------------------
   function automatic void put16(input logic [15:0] v);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[7:0]);
   endfunction

   // Header: ID, flags, question and answer counts, then random authority and additional
   // counts, which the parser ignores.
   function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                      input logic [15:0] qd, input logic [15:0] an);
      put16(id);
      put16(flags);
      put16(qd);
      put16(an);
      put16(16'($urandom));
      put16(16'($urandom));
   endfunction

   // A name of short random labels with the occasional full-length one, ended either
   // by the root label or by a compression pointer.
   function automatic void put_name(input int labels, input bit ptr);
      int n;
      repeat (labels) begin
         n = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 8);
         msg_bytes.push_back(8'(n));
         repeat (n) msg_bytes.push_back(8'($urandom));
      end
      if (ptr) begin
         msg_bytes.push_back(LABEL_KIND_MASK | 8'($urandom_range(0, 63)));
         msg_bytes.push_back(8'($urandom));
      end else begin
         msg_bytes.push_back(8'h00);
      end
   endfunction

   function automatic void put_question();
      put_name($urandom_range(0, 3), $urandom_range(0, 2) == 0);
      repeat (QTAIL_BYTES) msg_bytes.push_back(8'($urandom));
   endfunction

   // Record fixed part with a random TTL, followed by n_data random data bytes, which
   // may be fewer than the declared length to cut the record short.
   function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                      input logic [15:0] rdlen, input int n_data);
      put16(rtype);
      put16(rclass);
      put16(16'($urandom));
      put16(16'($urandom));
      put16(rdlen);
      repeat (n_data) msg_bytes.push_back(8'($urandom));
   endfunction

   // ---------------------------------------------------------------------------------
   // Directed tests.
   // ---------------------------------------------------------------------------------

   // Header checks: short headers, ID and flag failures, response codes, empty answers.
   task automatic test_header_checks();
      write_reg(CSR_EXPECTED_ID, 16'hA55A);
      write_reg(CSR_WANT_IPV6, 16'd0);
      // A single-byte message cannot hold a header.
      msg_bytes.push_back(8'hFF);
      send_message();
      // Name-error header cut one byte short is still malformed.
      put_header(cfg_id, FLAG_RESPONSE | RCODE_NXDOMAIN, 16'd1, 16'd1);
      void'(msg_bytes.pop_back());
      send_message();
      // Complete name-error header, with trailing bytes that must be ignored.
      put_header(cfg_id, FLAG_RESPONSE | RCODE_NXDOMAIN, 16'd1, 16'd0);
      put_question();
      send_message();
      // Wrong transaction ID.
      put_header(cfg_id ^ 16'h0001, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(1, 0);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      send_message();
      // Query rather than response.
      put_header(cfg_id, 16'h0000, 16'd0, 16'd0);
      send_message();
      // Truncated response.
      put_header(cfg_id, FLAG_RESPONSE | FLAG_TRUNCATED, 16'd0, 16'd0);
      send_message();
      // Response codes other than success and name-error.
      put_header(cfg_id, FLAG_RESPONSE | RCODE_SERVFAIL, 16'd0, 16'd0);
      send_message();
      put_header(cfg_id, FLAG_RESPONSE | RCODE_MASK, 16'd0, 16'd0);
      send_message();
      // No entries at all: nothing found, and the extra bytes after the verdict are ignored.
      put_header(cfg_id, 16'hFDF0, 16'd0, 16'd0);
      repeat (3) msg_bytes.push_back(8'($urandom));
      send_message();
   endtask

   // Name walking: illegal label kinds, compression pointers and maximum-length labels.
   task automatic test_name_forms();
      // Label length byte with the top bits 01.
      put_header(cfg_id, FLAG_RESPONSE, 16'd1, 16'd0);
      msg_bytes.push_back(8'h40);
      put_question();
      send_message();
      // Label length byte with the top bits 10.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      msg_bytes.push_back(8'hBF);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      send_message();
      // Question named by a pointer whose second byte is all ones, then an answer with
      // a 63-byte label that carries the address.
      put_header(cfg_id, FLAG_RESPONSE, 16'd1, 16'd1);
      msg_bytes.push_back(8'hC0);
      msg_bytes.push_back(8'hFF);
      put16(16'h0001);
      put16(16'h0001);
      msg_bytes.push_back(8'd63);
      repeat (63) msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(8'h00);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      send_message();
      // Huge question count with the message ending inside the entries.
      put_header(cfg_id, FLAG_RESPONSE, 16'hFFFF, 16'hFFFF);
      put_question();
      send_message();
   endtask

   // Record matching for both address families.
   task automatic test_record_matching();
      // Plain A record.
      put_header(cfg_id, FLAG_RESPONSE, 16'd1, 16'd1);
      put_question();
      put_name(2, 0);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      send_message();
      // Wrong class, then no answers left.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(0, 1);
      put_record(TYPE_A, 16'd3, LEN_A, 4);
      send_message();
      // Right type with the wrong length is skipped; the next record matches, and the
      // record after the verdict is ignored.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd3);
      put_name(1, 0);
      put_record(TYPE_A, CLASS_IN, LEN_AAAA, 16);
      put_name(0, 1);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      put_name(1, 1);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      send_message();
      // Empty data on a wanted type.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(1, 0);
      put_record(TYPE_A, CLASS_IN, 16'd0, 0);
      send_message();
      // Address data cut off.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(1, 0);
      put_record(TYPE_A, CLASS_IN, LEN_A, 2);
      send_message();

      write_reg(CSR_WANT_IPV6, 16'd1);
      // An A record is passed over when an AAAA record is sought.
      put_header(cfg_id, FLAG_RESPONSE, 16'd1, 16'd2);
      put_question();
      put_name(1, 0);
      put_record(TYPE_A, CLASS_IN, LEN_A, 4);
      put_name(0, 1);
      put_record(TYPE_AAAA, CLASS_IN, LEN_AAAA, 16);
      send_message();
      // AAAA with an IPv4-sized payload is not a match.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(1, 0);
      put_record(TYPE_AAAA, CLASS_IN, LEN_A, 4);
      send_message();
      // Record fixed part cut off one byte after the class.
      put_header(cfg_id, FLAG_RESPONSE, 16'd0, 16'd1);
      put_name(1, 0);
      put16(TYPE_AAAA);
      put16(CLASS_IN);
      msg_bytes.push_back(8'($urandom));
      send_message();
   endtask

   // ---------------------------------------------------------------------------------
   // Random traffic. Most messages are well formed with random names, counts, types and
   // lengths so that the record walk is exercised deeply; a few are pure noise, cut short
   // or have one byte corrupted.
   // ---------------------------------------------------------------------------------
   task automatic build_random_message();
      int          r;
      int          n_q;
      int          n_a;
      logic [15:0] id;
      logic [15:0] flags;
      logic [15:0] qd;
      logic [15:0] an;
      logic [15:0] rtype;
      logic [15:0] rclass;
      logic [15:0] rdlen;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 30)) msg_bytes.push_back(8'($urandom));
      end else begin
         id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_id;
         case ($urandom_range(0, 9))
            0: flags = 16'($urandom);
            1: flags = FLAG_RESPONSE | RCODE_NXDOMAIN | (16'($urandom) & 16'h7DF0);
            default: flags = FLAG_RESPONSE | (16'($urandom) & 16'h7DF0);
         endcase
         qd = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
         an = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
         n_q = (qd > 16'd3) ? $urandom_range(0, 3) : int'(qd);
         n_a = (an > 16'd4) ? $urandom_range(0, 4) : int'(an);
         put_header(id, flags, qd, an);
         repeat (n_q) put_question();
         repeat (n_a) begin
            put_name($urandom_range(0, 3), $urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) rtype = cfg_ipv6 ? TYPE_AAAA : TYPE_A;
            else if (r < 70) rtype = cfg_ipv6 ? TYPE_A : TYPE_AAAA;
            else rtype = 16'($urandom);
            rclass = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 4)) : CLASS_IN;
            r = $urandom_range(0, 99);
            if (r < 75) rdlen = (rtype == TYPE_AAAA) ? LEN_AAAA : LEN_A;
            else if (r < 97) rdlen = 16'($urandom_range(0, 20));
            else rdlen = 16'($urandom_range(256, 600));
            put_record(rtype, rclass, rdlen, int'(rdlen));
         end
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
         r = $urandom_range(0, 99);
         if (r < 10) begin
            n_q = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > n_q) void'(msg_bytes.pop_back());
         end else if (r < 15) begin
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
         end
      end
   endtask

   task automatic test_random_traffic(input logic [15:0] id, input logic ipv6);
      int bytes_sent;
      write_reg(CSR_EXPECTED_ID, id);
      write_reg(CSR_WANT_IPV6, {15'd0, ipv6});
      bytes_sent = 0;
      while (bytes_sent < 40) begin
         build_random_message();
         bytes_sent = bytes_sent + msg_bytes.size();
         send_message();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence: reset, directed tests, then random traffic under the extreme and random
   // register settings, and finally the drain and verdict.
   // ---------------------------------------------------------------------------------
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_EXPECTED_ID;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_checks();
      test_name_forms();
      test_record_matching();
      test_random_traffic(16'hFFFF, 1'b1);
      test_random_traffic(16'($urandom), 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (expected_answers.size() != 0) begin
         $error("%0d expected results never arrived", expected_answers.size());
         failed = 1'b1;
      end
      if (!failed) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
